FILE: design/psu_pkg.sv
// Shared types and constants for the PNG scanline unfilter.
// Used by psu_recon, png_scanline_unfilter and psu_checker; depends on nothing.
`default_nettype none

package psu_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int COL_W       = $clog2(STORE_DEPTH);
    localparam int STRIDE_W    = COL_W + 1;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_RGBA   = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       start_of_image;
    } in_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       end_of_row;
        logic       end_of_image;
        logic       bad_filter;
    } out_t;

endpackage

`default_nettype wire

FILE: design/psu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module psu_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: design/psu_recon.sv
// Byte reconstruction for the five PNG filter types (None, Sub, Up, Average, Paeth).
// Purely combinational; depends on psu_pkg.
`default_nettype none

module psu_recon (
    input  wire psu_pkg::filter_t filter,
    input  wire logic [7:0]       sample,
    input  wire logic [7:0]       left,
    input  wire logic [7:0]       up,
    input  wire logic [7:0]       upleft,
    output logic      [7:0]       result
);

    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_abc;
    logic        [9:0] pa;
    logic        [9:0] pb;
    logic        [9:0] pc;
    logic        [7:0] pred;
    logic        [8:0] avg_sum;

    // pa = |p - a| = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    assign d_bc  = $signed({2'b00, up})   - $signed({2'b00, upleft});
    assign d_ac  = $signed({2'b00, left}) - $signed({2'b00, upleft});
    assign d_abc = $signed({2'b00, left}) + $signed({2'b00, up})
                 - $signed({1'b0, upleft, 1'b0});
    assign pa = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    assign pb = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
    assign pc = d_abc[9] ? 10'(-d_abc) : 10'(d_abc);

    assign avg_sum = {1'b0, left} + {1'b0, up};

    always_comb
    begin
        case (filter)
            psu_pkg::FILT_SUB:   pred = left;
            psu_pkg::FILT_UP:    pred = up;
            psu_pkg::FILT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                    pred = left;
                else if (pb <= pc)
                    pred = up;
                else
                    pred = upleft;
            end
            default:             pred = 8'd0;
        endcase
        result = sample + pred;
    end

endmodule

`default_nettype wire

FILE: design/png_scanline_unfilter.sv
// Top level of the PNG scanline unfilter (filter method 0, 8-bit RGB/RGBA).
// Depends on psu_pkg, psu_ram and psu_recon.
//
// Usage:
//   in_*  : inflated stream, one byte per transfer. The first byte of each row
//           is the filter code and yields no output; start_of_image forces a
//           restart at row 0 with that byte taken as the filter code.
//   out_* : one reconstructed sample per data byte, tagged with end_of_row,
//           end_of_image and bad_filter (filter code above 4, decoded as None).
//   cfg_* : register writes (width, height, rgba mode); always ready. Write
//           only while no transfer is in flight.
// A data byte is registered in the reconstruct stage, then in the output
// register. Throughput: one byte per cycle while out_stall does not hold it.
// The row-above store is a RAM with registered read, addressed one stage ahead
// of the reconstruct stage, which sets the two-stage pipeline depth.
// Reset: pipeline emptied, next byte is a filter code, registers return to
// width 1, height 1, RGB. The row store is not cleared; row 0 ignores what it reads.
// Stall: out_stall holds the output register; once the reconstruct stage is
// also full, in_stall rises in the same cycle.
`default_nettype none

module png_scanline_unfilter (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire psu_pkg::in_t                         in_data,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output psu_pkg::out_t                             out_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0]       cfg_data
);

    typedef struct packed {
        logic [7:0]                  sample;
        logic [psu_pkg::COL_W-1:0]   col;
        logic                        row0;
        psu_pkg::filter_t            filter;
        logic                        bad;
        logic                        row_end;
        logic                        img_end;
    } stage_t;

    // configuration
    logic [psu_pkg::WIDTH_W-1:0]  cfg_width_reg;
    logic [psu_pkg::HEIGHT_W-1:0] cfg_height_reg;
    logic                         cfg_rgba_reg;

    // row tracking
    logic [psu_pkg::COL_W-1:0]    col_reg;
    logic [psu_pkg::HEIGHT_W-1:0] row_reg;
    psu_pkg::filter_t             filter_reg;
    logic                         bad_reg;
    logic                         expect_reg;

    // reconstruct stage and output register
    logic                         s1_valid_reg;
    stage_t                       s1_reg;
    stage_t                       s1_next;
    logic [31:0]                  left_reg;
    logic [31:0]                  upleft_reg;
    logic                         out_valid_reg;
    psu_pkg::out_t                out_reg;

    logic                         in_fire;
    logic                         s1_adv;
    logic                         is_filter;
    logic [psu_pkg::HEIGHT_W-1:0] row_eff;
    logic [psu_pkg::WIDTH_W-1:0]  width_eff;
    logic [psu_pkg::HEIGHT_W-1:0] height_eff;
    logic [psu_pkg::STRIDE_W-1:0] stride;
    logic                         row_end;
    logic                         img_end;

    logic [7:0]                   ram_rd;
    logic [31:0]                  left_eff;
    logic [31:0]                  upleft_eff;
    logic [7:0]                   up;
    logic [7:0]                   left_b;
    logic [7:0]                   upleft_b;
    logic [7:0]                   result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_width_reg  <= psu_pkg::WIDTH_W'(1);
            cfg_height_reg <= psu_pkg::HEIGHT_W'(1);
            cfg_rgba_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                psu_pkg::CFG_WIDTH:  cfg_width_reg  <= cfg_data[psu_pkg::WIDTH_W-1:0];
                psu_pkg::CFG_HEIGHT: cfg_height_reg <= cfg_data[psu_pkg::HEIGHT_W-1:0];
                psu_pkg::CFG_RGBA:   cfg_rgba_reg   <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // ---------------- accept side ----------------
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_fire  = in_valid && !in_stall;

    assign is_filter = expect_reg || in_data.start_of_image;
    assign row_eff   = in_data.start_of_image ? '0 : row_reg;

    always_comb
    begin
        if (cfg_width_reg == '0)
            width_eff = psu_pkg::WIDTH_W'(1);
        else if (32'(cfg_width_reg) > psu_pkg::MAX_WIDTH)
            width_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
        else
            width_eff = cfg_width_reg;
        height_eff = (cfg_height_reg == '0) ? psu_pkg::HEIGHT_W'(1) : cfg_height_reg;
        if (cfg_rgba_reg)
            stride = psu_pkg::STRIDE_W'(width_eff) << 2;
        else
            stride = (psu_pkg::STRIDE_W'(width_eff) << 1) + psu_pkg::STRIDE_W'(width_eff);
        row_end = ({1'b0, col_reg} + psu_pkg::STRIDE_W'(1)) >= stride;
        img_end = row_end
                && ({1'b0, row_reg} + 17'd1) >= {1'b0, height_eff};
    end

    always_comb
    begin
        s1_next.sample  = in_data.stream_byte;
        s1_next.col     = col_reg;
        s1_next.row0    = (row_reg == '0);
        s1_next.filter  = filter_reg;
        s1_next.bad     = bad_reg;
        s1_next.row_end = row_end;
        s1_next.img_end = img_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            filter_reg <= psu_pkg::FILT_NONE;
            bad_reg    <= 1'b0;
            expect_reg <= 1'b1;
        end
        else if (in_fire)
        begin
            if (is_filter)
            begin
                expect_reg <= 1'b0;
                col_reg    <= '0;
                row_reg    <= row_eff;
                if (in_data.stream_byte > 8'(psu_pkg::FILT_PAETH))
                begin
                    bad_reg    <= 1'b1;
                    filter_reg <= psu_pkg::FILT_NONE;
                end
                else
                begin
                    bad_reg    <= 1'b0;
                    filter_reg <= psu_pkg::filter_t'(in_data.stream_byte[2:0]);
                end
            end
            else if (row_end)
            begin
                col_reg    <= '0;
                expect_reg <= 1'b1;
                row_reg    <= img_end ? '0 : row_reg + psu_pkg::HEIGHT_W'(1);
            end
            else
            begin
                col_reg <= col_reg + psu_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= !is_filter;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !is_filter)
            s1_reg <= s1_next;
    end

    // Row-above store: read as the byte enters, written as it leaves stage 1.
    // The same column is read again only a full row later, so no bypass.
    psu_ram #(
        .DATA_W (8),
        .DEPTH  (psu_pkg::STORE_DEPTH)
    ) u_prev_row (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.col),
        .wr_data (result),
        .rd_en   (in_fire && !is_filter),
        .rd_addr (col_reg),
        .rd_data (ram_rd)
    );

    // ---------------- reconstruct stage ----------------
    // First byte of a row starts with empty left/upleft history.
    assign left_eff   = (s1_reg.col == '0) ? '0 : left_reg;
    assign upleft_eff = (s1_reg.col == '0) ? '0 : upleft_reg;
    assign up         = s1_reg.row0 ? 8'd0 : ram_rd;
    assign left_b     = cfg_rgba_reg ? left_eff[31:24]   : left_eff[23:16];
    assign upleft_b   = cfg_rgba_reg ? upleft_eff[31:24] : upleft_eff[23:16];

    psu_recon u_recon (
        .filter (s1_reg.filter),
        .sample (s1_reg.sample),
        .left   (left_b),
        .up     (up),
        .upleft (upleft_b),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            upleft_reg <= '0;
        end
        else if (s1_adv)
        begin
            left_reg   <= {left_eff[23:0], result};
            upleft_reg <= {upleft_eff[23:0], up};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg.pixel_byte   <= result;
            out_reg.end_of_row   <= s1_reg.row_end;
            out_reg.end_of_image <= s1_reg.img_end;
            out_reg.bad_filter   <= s1_reg.bad;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: design/psu_checker.sv
// Port-level checks for png_scanline_unfilter, attached by bind.
// Depends on psu_pkg.
`default_nettype none

module psu_port_checks (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire psu_pkg::in_t                   in_data,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire psu_pkg::out_t                  out_data,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready,
    input wire logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A held result keeps its contents until transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // Backpressure reaches the input only when the output side is blocked.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // The last byte of an image always closes a row.
    a_eoi_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.end_of_image |-> out_data.end_of_row)
        else $error("end_of_image without end_of_row");

    // A fresh result follows a data byte transfer via the reconstruct stage and output register, never a restart byte.
    a_filter_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && !in_data.start_of_image, 2))
        else $error("result without a data byte transfer");

    // Configuration port never blocks.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused (index %0d, data %0h)", cfg_index, cfg_data);

endmodule

bind png_scanline_unfilter psu_port_checks u_port_checks (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);

`default_nettype wire

FILE: test/psu_checker.sv
// Scoreboard for the PNG scanline unfilter: follows every transfer on the input, output
// and register channels, predicts each reconstructed byte and compares it with the block.
// Depends on psu_pkg.
`timescale 1ns / 100ps

module psu_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire psu_pkg::in_t                   in_data,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire psu_pkg::out_t                  out_data,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [psu_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                  mismatches,
    output int                                  pending
);

    localparam int REPORT_LIMIT = 10;

    // geometry registers as the block should hold them
    logic [psu_pkg::WIDTH_W-1:0]  geo_width;
    logic [psu_pkg::HEIGHT_W-1:0] geo_height;
    logic                         geo_rgba;

    // predicted unfilter state
    logic [7:0]       above_row [psu_pkg::STORE_DEPTH];
    logic [31:0]      left_hist;
    logic [31:0]      upleft_hist;
    logic [11:0]      col_num;
    logic [15:0]      row_num;
    psu_pkg::filter_t row_filt;
    logic             want_filter;
    logic             row_bad;

    psu_pkg::out_t    recon_q [$];
    psu_pkg::out_t    oldest;
    int               errs;

    function automatic logic [7:0] paeth_predict(input int a, input int b, input int c);
        int pa;
        int pb;
        int pc;
        pa = (b > c) ? b - c : c - b;
        pb = (a > c) ? a - c : c - a;
        pc = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
        if (pa <= pb && pa <= pc)
            return 8'(a);
        if (pb <= pc)
            return 8'(b);
        return 8'(c);
    endfunction

    // Advance the row state by one stream byte; queue the sample it yields, if any.
    task automatic unfilter_byte(input psu_pkg::in_t item);
        int         bpp;
        int         eff_w;
        int         eff_h;
        int         stride;
        int         shift;
        int         sum;
        logic [7:0] sample;
        logic [7:0] left_b;
        logic [7:0] up_b;
        logic [7:0] upleft_b;
        logic [7:0] pix;
        logic       row_end;
        logic       img_end;
        bpp    = geo_rgba ? 4 : 3;
        eff_w  = (geo_width == 0) ? 1
               : (geo_width > psu_pkg::MAX_WIDTH ? psu_pkg::MAX_WIDTH : int'(geo_width));
        eff_h  = (geo_height == 0) ? 1 : int'(geo_height);
        stride = eff_w * bpp;
        sample = item.stream_byte;

        if (item.start_of_image)
        begin
            row_num     = '0;
            col_num     = '0;
            want_filter = 1'b1;
        end

        if (want_filter)
        begin
            row_bad     = sample > 8'(psu_pkg::FILT_PAETH);
            row_filt    = row_bad ? psu_pkg::FILT_NONE : psu_pkg::filter_t'(sample[2:0]);
            want_filter = 1'b0;
            left_hist   = '0;
            upleft_hist = '0;
            col_num     = '0;
            return;
        end

        shift    = 8 * (bpp - 1);
        left_b   = 8'(left_hist >> shift);
        upleft_b = 8'(upleft_hist >> shift);
        up_b     = (row_num > 0) ? above_row[col_num] : 8'd0;

        case (row_filt)
            psu_pkg::FILT_SUB:   pix = sample + left_b;
            psu_pkg::FILT_UP:    pix = sample + up_b;
            psu_pkg::FILT_AVG:
            begin
                sum = int'(left_b) + int'(up_b);
                pix = sample + 8'(sum >> 1);
            end
            psu_pkg::FILT_PAETH:
                pix = sample + paeth_predict(int'(left_b), int'(up_b), int'(upleft_b));
            default:             pix = sample;
        endcase

        above_row[col_num] = pix;
        left_hist   = {left_hist[23:0], pix};
        upleft_hist = {upleft_hist[23:0], up_b};

        row_end = int'(col_num) + 1 >= stride;
        img_end = row_end && (int'(row_num) + 1 >= eff_h);
        recon_q.insert(recon_q.size(), psu_pkg::out_t'({pix, row_end, img_end, row_bad}));

        if (row_end)
        begin
            col_num     = '0;
            want_filter = 1'b1;
            row_num     = img_end ? 16'd0 : row_num + 16'd1;
        end
        else
            col_num = col_num + 12'd1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_width   = 11'd1;
            geo_height  = 16'd1;
            geo_rgba    = 1'b0;
            left_hist   = '0;
            upleft_hist = '0;
            col_num     = '0;
            row_num     = '0;
            row_filt    = psu_pkg::FILT_NONE;
            want_filter = 1'b1;
            row_bad     = 1'b0;
            errs        = 0;
            recon_q.delete();
            mismatches <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (psu_pkg::cfg_idx_t'(cfg_index))
                    psu_pkg::CFG_WIDTH:  geo_width  = cfg_data[psu_pkg::WIDTH_W-1:0];
                    psu_pkg::CFG_HEIGHT: geo_height = cfg_data[psu_pkg::HEIGHT_W-1:0];
                    psu_pkg::CFG_RGBA:   geo_rgba   = cfg_data[0];
                    default:             ;
                endcase
            end

            if (in_valid && !in_stall)
                unfilter_byte(in_data);

            if (out_valid && !out_stall)
            begin
                if (recon_q.size() == 0)
                begin
                    errs++;
                    if (errs <= REPORT_LIMIT)
                        $display("%0t: unexpected transfer pixel %02h eor %b eoi %b bad %b",
                                 $time, out_data.pixel_byte, out_data.end_of_row,
                                 out_data.end_of_image, out_data.bad_filter);
                end
                else
                begin
                    oldest = recon_q.pop_front();
                    if (out_data.pixel_byte !== oldest.pixel_byte
                        || out_data.end_of_row !== oldest.end_of_row
                        || out_data.end_of_image !== oldest.end_of_image
                        || out_data.bad_filter !== oldest.bad_filter)
                    begin
                        errs++;
                        if (errs <= REPORT_LIMIT)
                            $display({"%0t: mismatch exp/got pixel %02h/%02h",
                                      " eor %b/%b eoi %b/%b bad %b/%b"},
                                     $time, oldest.pixel_byte, out_data.pixel_byte,
                                     oldest.end_of_row, out_data.end_of_row,
                                     oldest.end_of_image, out_data.end_of_image,
                                     oldest.bad_filter, out_data.bad_filter);
                    end
                end
            end

            mismatches <= errs;
            pending    <= recon_q.size();
        end
    end

endmodule

FILE: test/png_scanline_unfilter_tb.sv
// Testbench top for png_scanline_unfilter: drives filtered scanline streams and geometry
// writes with random idling; psu_checker does the prediction. Depends on psu_pkg.
`timescale 1ns / 100ps

module png_scanline_unfilter_tb;

    localparam int          DRAIN_CYCLES = 20;
    localparam int          RANDOM_BYTES = 1270;
    localparam int          WIDE_PART    = 64;
    localparam logic [7:0]  CODE_BAD_LOW = 8'd5;
    localparam logic [7:0]  CODE_BAD_TOP = 8'hFF;
    localparam logic [47:0] EDGE_BYTES   = 48'h00FF807F01FE;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    psu_pkg::in_t                   in_data;
    logic                           out_valid;
    logic                           out_stall;
    psu_pkg::out_t                  out_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [psu_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             mismatches;
    int                             pending;

    bit calm;
    bit gappy;
    int cur_stride;
    int cur_rows;
    int sent_bytes;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    png_scanline_unfilter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psu_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic logic [7:0] code_of(input psu_pkg::filter_t f);
        return {5'd0, f};
    endfunction

    // mostly legal filter codes, with the invalid range hit now and then
    function automatic logic [7:0] pick_code();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return CODE_BAD_LOW;
        if (roll == 1)
            return CODE_BAD_TOP;
        if (roll == 2)
            return 8'($urandom_range(int'(CODE_BAD_LOW), int'(CODE_BAD_TOP)));
        return code_of(psu_pkg::filter_t'($urandom_range(int'(psu_pkg::FILT_NONE),
                                                         int'(psu_pkg::FILT_PAETH))));
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic restart);
        in_valid <= 1'b1;
        in_data  <= psu_pkg::in_t'({value, restart});
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_bytes++;
        if (gappy && !calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // pattern < 0 gives random samples, otherwise a rotation of the corner values
    task automatic send_row(input logic [7:0] code, input logic restart, input int count,
                            input int pattern);
        push_byte(code, restart);
        for (int k = 0; k < count; k++)
            push_byte(pattern < 0 ? 8'($urandom_range(0, 255))
                                  : EDGE_BYTES[8 * ((k + pattern) % 6) +: 8], 1'b0);
    endtask

    // a row is sometimes cut short; the caller then restarts the next image
    task automatic send_image(input logic restart, input int rows, output bit cut);
        int n;
        cut = 1'b0;
        for (int r = 0; r < rows && !cut; r++)
        begin
            n = cur_stride;
            if ($urandom_range(0, 15) == 0)
            begin
                n   = $urandom_range(0, cur_stride - 1);
                cut = 1'b1;
            end
            send_row(pick_code(), restart && r == 0, n, -1);
        end
    endtask

    // wait until every predicted sample has come out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input psu_pkg::cfg_idx_t idx, input int value);
        cfg_index <= idx;
        cfg_data  <= psu_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input logic rgba);
        int eff_w;
        settle();
        cfg_valid <= 1'b1;
        write_reg(psu_pkg::CFG_WIDTH, w);
        write_reg(psu_pkg::CFG_HEIGHT, h);
        write_reg(psu_pkg::CFG_RGBA, int'(rgba));
        cfg_valid <= 1'b0;
        eff_w      = (w == 0) ? 1 : (w > psu_pkg::MAX_WIDTH ? psu_pkg::MAX_WIDTH : w);
        cur_stride = eff_w * (rgba ? 4 : 3);
        cur_rows   = (h == 0) ? 1 : h;
    endtask

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(40, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 12)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) != 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        bit cut;
        int w;
        int h;
        int base;
        in_valid   <= 1'b0;
        in_data    <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= psu_pkg::CFG_WIDTH;
        cfg_data   <= '0;
        rst_n      <= 1'b0;
        calm       = 1'b0;
        gappy      = 1'b1;
        sent_bytes = 0;
        cur_stride = 3;
        cur_rows   = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // every filter on corner samples; the second image follows end of image directly
        set_geometry(1, 2, 1'b0);
        send_row(code_of(psu_pkg::FILT_NONE), 1'b1, 3, 0);
        send_row(code_of(psu_pkg::FILT_UP), 1'b0, 3, 1);
        send_row(CODE_BAD_LOW, 1'b0, 3, 2);
        send_row(code_of(psu_pkg::FILT_AVG), 1'b0, 3, 3);
        set_geometry(2, 2, 1'b0);
        send_row(code_of(psu_pkg::FILT_SUB), 1'b1, 6, 4);
        send_row(code_of(psu_pkg::FILT_PAETH), 1'b0, 6, 5);

        // geometry extremes: full-store and clamped widths on short cut rows,
        // zero height, zero width on the tallest image
        set_geometry(psu_pkg::MAX_WIDTH, 2, 1'b1);
        send_row(pick_code(), 1'b1, WIDE_PART, -1);
        set_geometry(2047, 0, 1'b0);
        send_row(pick_code(), 1'b1, WIDE_PART, -1);
        set_geometry(2, 0, 1'b0);
        send_image(1'b1, cur_rows, cut);
        set_geometry(0, 65535, 1'b1);
        send_image(1'b1, 3, cut);

        base = sent_bytes;
        while (sent_bytes - base < RANDOM_BYTES)
        begin
            calm  = (sent_bytes - base) > RANDOM_BYTES * 4 / 5;
            gappy = $urandom_range(0, 3) != 0;
            w     = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            h     = $urandom_range(1, 4);
            set_geometry(w, h, 1'($urandom_range(0, 1)));
            cut = 1'b1;
            repeat ($urandom_range(1, 3))
                send_image(cut || $urandom_range(0, 1) == 0, cur_rows, cut);
        end

        settle();
        @(negedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
